>>> hdl/gddrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gddrc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAP_DIM   = 32;
    localparam int MAP_W     = $clog2(MAP_DIM);
    localparam int ADDR_W    = 2 * MAP_W;
    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    localparam logic signed [31:0] ONE       = 32'sd65536;
    localparam logic        [31:0] DELTA_SAT = 32'h7FFF_FFFF;
    localparam logic        [21:0] PERP_MAX  = 22'h3F_FFFF;
    localparam logic        [20:0] FLOOR_MAX = 21'h1F_FFFF;

    // iteration counts of the shared divider and multiplier
    localparam logic [5:0] DIV_ITER = 6'd33;
    localparam logic [5:0] MUL_ITER = 6'd32;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    localparam logic [3:0] REG_WIDTH  = 4'd0;
    localparam logic [3:0] REG_HEIGHT = 4'd1;
    localparam logic [3:0] REG_CAM_X  = 4'd2;
    localparam logic [3:0] REG_CAM_Y  = 4'd3;
    localparam logic [3:0] REG_DIR_X  = 4'd4;
    localparam logic [3:0] REG_DIR_Y  = 4'd5;
    localparam logic [3:0] REG_PLN_X  = 4'd6;
    localparam logic [3:0] REG_PLN_Y  = 4'd7;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [15:0] sat16s(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        sat16s = r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/grid_dda_column_raycaster_core.sv
// Column raycaster over a 32 x 32 grid of 4-bit wall codes, Q16.16 maths.
// A map-write item is written as it is taken, and the block stays idle. A
// cast item runs through one shared restoring divider and one shift-add
// multiplier under a sequencer, then walks the grid cell by cell in three
// states (step, bounds test, map read) until it hits a wall, leaves the
// map or runs out of steps. After reset the map is zeroed one cell per
// cycle, all 1024 cells, before the first item is taken. Config writes are
// always taken and must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module grid_dda_column_raycaster_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [20:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic               i_mode,
    input  wire logic [10:0]        i_column,
    input  wire logic [4:0]         i_cell_row,
    input  wire logic [4:0]         i_cell_col,
    input  wire logic [3:0]         i_cell_value,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic [10:0]        o_out_column,
    output      logic [3:0]         o_wall_code,
    output      logic               o_hit_side,
    output      logic [21:0]        o_perp_distance,
    output      logic [15:0]        o_line_height,
    output      logic signed [15:0] o_draw_top,
    output      logic signed [15:0] o_draw_bottom,
    output      logic [15:0]        o_wall_fraction,
    output      logic [20:0]        o_floor_point_x,
    output      logic [20:0]        o_floor_point_y,
    output      logic               o_escaped
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CAM  = 4'd2;
    localparam logic [3:0] S_RDX  = 4'd3;
    localparam logic [3:0] S_RDY  = 4'd4;
    localparam logic [3:0] S_DX   = 4'd5;
    localparam logic [3:0] S_DY   = 4'd6;
    localparam logic [3:0] S_SX   = 4'd7;
    localparam logic [3:0] S_SY   = 4'd8;
    localparam logic [3:0] S_STEP = 4'd9;
    localparam logic [3:0] S_CHK  = 4'd10;
    localparam logic [3:0] S_RD   = 4'd11;
    localparam logic [3:0] S_PERP = 4'd12;
    localparam logic [3:0] S_LH   = 4'd13;
    localparam logic [3:0] S_WP   = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    localparam int CW = gddrc_pkg::MAP_W + 2;

    // configuration
    logic [11:0]        r_width, r_height;
    logic [20:0]        r_cam_x, r_cam_y;
    logic signed [18:0] r_dir_x, r_dir_y, r_pln_x, r_pln_y;

    logic [3:0]  r_state;
    logic [5:0]  r_cnt;
    logic [gddrc_pkg::ADDR_W-1:0] r_clr;
    logic [10:0] r_col;

    // shared divider and multiplier
    logic [31:0] r_rem, r_den;
    logic [32:0] r_quo;
    logic [63:0] r_ma, r_acc;
    logic [31:0] r_mb;
    logic        r_neg;

    logic signed [31:0] r_cam, r_rdx, r_rdy;
    logic [31:0] r_dx, r_dy;
    logic [39:0] r_sx, r_sy;
    logic signed [CW-1:0] r_mx, r_my;
    logic        r_side;
    logic [gddrc_pkg::STEP_W-1:0] r_steps;
    logic [3:0]  r_code, r_rd;
    logic [21:0] r_perp;
    logic [15:0] r_lh;

    logic [3:0] r_map [gddrc_pkg::MAP_DIM * gddrc_pkg::MAP_DIM];

    logic [10:0] r_o_col;
    logic [3:0]  r_o_code;
    logic        r_o_side, r_o_esc;
    logic [21:0] r_o_perp;
    logic [15:0] r_o_lh, r_o_top, r_o_bot, r_o_frac;
    logic [20:0] r_o_fx, r_o_fy;

    logic        in_fire;
    logic [32:0] div_trial, div_sub;
    logic        div_ge;
    logic [31:0] div_rem_nx;
    logic [32:0] div_quo_nx;
    logic [63:0] mul_acc_nx, mul_res;
    logic signed [31:0] cam_q, rd_nx;
    logic [31:0] dsat, cam_den;
    logic [16:0] fdist_x, fdist_y;
    logic        out_of_map;
    logic [40:0] perp_raw;
    logic [21:0] perp_c;
    logic [15:0] fr;
    logic        rdx_pos, rdy_pos, rdx_neg;
    logic [CW-2:0] mx_u, my_u, mx1, my1;
    logic [21:0] fpx, fpy;
    logic signed [17:0] top_v, bot_v;
    logic        mem_we;
    logic [gddrc_pkg::ADDR_W-1:0] mem_wa, rd_addr;
    logic [3:0]  mem_wd;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_fire     = i_in_valid && o_in_ready;

    assign div_trial  = {r_rem, r_quo[32]};
    assign div_sub    = div_trial - {1'b0, r_den};
    assign div_ge     = (div_trial >= {1'b0, r_den});
    assign div_rem_nx = div_ge ? div_sub[31:0] : div_trial[31:0];
    assign div_quo_nx = {r_quo[31:0], div_ge};
    assign mul_acc_nx = r_mb[0] ? r_acc + r_ma : r_acc;
    assign mul_res    = r_neg ? 64'(-r_acc) : r_acc;

    assign cam_q   = $signed({1'b0, r_quo[30:0]}) - gddrc_pkg::ONE;
    assign rd_nx   = $signed(mul_res[47:16]);
    assign dsat    = (r_quo[32] || r_quo[31]) ? gddrc_pkg::DELTA_SAT : {1'b0, r_quo[30:0]};
    assign cam_den = (r_width == 12'd0) ? 32'd1 : {20'd0, r_width};
    assign fdist_x = r_rdx[31] ? {1'b0, r_cam_x[15:0]} : 17'h10000 - {1'b0, r_cam_x[15:0]};
    assign fdist_y = r_rdy[31] ? {1'b0, r_cam_y[15:0]} : 17'h10000 - {1'b0, r_cam_y[15:0]};

    assign out_of_map = (r_mx < 0) || (r_mx >= CW'(gddrc_pkg::MAP_DIM))
                     || (r_my < 0) || (r_my >= CW'(gddrc_pkg::MAP_DIM));

    assign perp_raw = r_side ? {1'b0, r_sy} - {9'd0, r_dy} : {1'b0, r_sx} - {9'd0, r_dx};
    assign perp_c   = perp_raw[40] ? 22'd0 :
                      (perp_raw[39:0] > {18'd0, gddrc_pkg::PERP_MAX}) ? gddrc_pkg::PERP_MAX :
                      perp_raw[21:0];

    // low half of camera + floor(perp * dir >> 16) on the axis along the wall
    assign fr = (r_side ? r_cam_x[15:0] : r_cam_y[15:0]) + mul_res[31:16];

    assign rdx_pos = !r_rdx[31] && (r_rdx != 32'sd0);
    assign rdx_neg = r_rdx[31];
    assign rdy_pos = !r_rdy[31] && (r_rdy != 32'sd0);
    assign mx_u    = r_mx[CW-2:0];
    assign my_u    = r_my[CW-2:0];
    assign mx1     = mx_u + 1'b1;
    assign my1     = my_u + 1'b1;

    always_comb begin
        if (!r_side && rdx_pos) begin
            fpx = {mx_u, 16'd0};
            fpy = {my_u, fr};
        end else if (!r_side && rdx_neg) begin
            fpx = {mx1, 16'd0};
            fpy = {my_u, fr};
        end else if (r_side && rdy_pos) begin
            fpx = {mx_u, fr};
            fpy = {my_u, 16'd0};
        end else begin
            fpx = {mx_u, fr};
            fpy = {my1, 16'd0};
        end
    end

    assign top_v = $signed({7'd0, r_height[11:1]}) - $signed({3'd0, r_lh[15:1]});
    assign bot_v = $signed({7'd0, r_height[11:1]}) + $signed({3'd0, r_lh[15:1]});

    // map store: clearing sweep or item write, one read port for the walk
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = 4'd0;
        if (r_state == S_CLR) begin
            mem_we = i_rst_n;
        end else if (in_fire && i_mode == gddrc_pkg::MODE_WRITE
                     && int'(i_cell_row) < gddrc_pkg::MAP_DIM
                     && int'(i_cell_col) < gddrc_pkg::MAP_DIM) begin
            mem_we = i_rst_n;
            mem_wa = {i_cell_row[gddrc_pkg::MAP_W-1:0], i_cell_col[gddrc_pkg::MAP_W-1:0]};
            mem_wd = i_cell_value;
        end
    end

    assign rd_addr = {r_mx[gddrc_pkg::MAP_W-1:0], r_my[gddrc_pkg::MAP_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        r_rd <= r_map[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_cam_x  <= 21'd1441792;
            r_cam_y  <= 21'd753664;
            r_dir_x  <= -19'sd65536;
            r_dir_y  <= 19'sd0;
            r_pln_x  <= 19'sd0;
            r_pln_y  <= 19'sd43254;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gddrc_pkg::REG_WIDTH:  r_width  <= i_cfg_data[11:0];
                gddrc_pkg::REG_HEIGHT: r_height <= i_cfg_data[11:0];
                gddrc_pkg::REG_CAM_X:  r_cam_x  <= i_cfg_data;
                gddrc_pkg::REG_CAM_Y:  r_cam_y  <= i_cfg_data;
                gddrc_pkg::REG_DIR_X:  r_dir_x  <= $signed(i_cfg_data[18:0]);
                gddrc_pkg::REG_DIR_Y:  r_dir_y  <= $signed(i_cfg_data[18:0]);
                gddrc_pkg::REG_PLN_X:  r_pln_x  <= $signed(i_cfg_data[18:0]);
                gddrc_pkg::REG_PLN_Y:  r_pln_y  <= $signed(i_cfg_data[18:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == gddrc_pkg::ADDR_W'(gddrc_pkg::MAP_DIM * gddrc_pkg::MAP_DIM - 1))
                    begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire && i_mode == gddrc_pkg::MODE_CAST) begin
                        r_col   <= i_column;
                        r_rem   <= '0;
                        r_quo   <= {5'd0, i_column, 17'd0};
                        r_den   <= cam_den;
                        r_cnt   <= gddrc_pkg::DIV_ITER;
                        r_state <= S_CAM;
                    end
                end
                S_CAM, S_DX, S_DY, S_LH: begin
                    if (r_cnt != 6'd0) begin
                        r_rem <= div_rem_nx;
                        r_quo <= div_quo_nx;
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_state == S_CAM) begin
                        r_cam   <= cam_q;
                        r_ma    <= {45'd0, 19'(gddrc_pkg::abs32(32'(r_pln_x)))};
                        r_mb    <= gddrc_pkg::abs32(cam_q);
                        r_neg   <= r_pln_x[18] ^ cam_q[31];
                        r_acc   <= '0;
                        r_cnt   <= gddrc_pkg::MUL_ITER;
                        r_state <= S_RDX;
                    end else if (r_state == S_DX) begin
                        r_dx    <= dsat;
                        r_rem   <= '0;
                        r_quo   <= 33'h1_0000_0000;
                        r_den   <= gddrc_pkg::abs32(r_rdy);
                        r_cnt   <= gddrc_pkg::DIV_ITER;
                        r_state <= S_DY;
                    end else if (r_state == S_DY) begin
                        r_dy    <= dsat;
                        r_ma    <= {32'd0, r_dx};
                        r_mb    <= {15'd0, fdist_x};
                        r_neg   <= 1'b0;
                        r_acc   <= '0;
                        r_cnt   <= gddrc_pkg::MUL_ITER;
                        r_state <= S_SX;
                    end else begin
                        // zero distance divides to all ones and saturates
                        r_lh    <= (r_quo[32:16] != 17'd0) ? 16'hFFFF : r_quo[15:0];
                        r_ma    <= {42'd0, r_perp};
                        r_mb    <= gddrc_pkg::abs32(r_side ? r_rdx : r_rdy);
                        r_neg   <= r_side ? r_rdx[31] : r_rdy[31];
                        r_acc   <= '0;
                        r_cnt   <= gddrc_pkg::MUL_ITER;
                        r_state <= S_WP;
                    end
                end
                S_RDX, S_RDY, S_SX, S_SY, S_WP: begin
                    if (r_cnt != 6'd0) begin
                        r_acc <= mul_acc_nx;
                        r_ma  <= {r_ma[62:0], 1'b0};
                        r_mb  <= {1'b0, r_mb[31:1]};
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_state == S_RDX) begin
                        r_rdx   <= 32'(r_dir_x) + rd_nx;
                        r_ma    <= {45'd0, 19'(gddrc_pkg::abs32(32'(r_pln_y)))};
                        r_mb    <= gddrc_pkg::abs32(r_cam);
                        r_neg   <= r_pln_y[18] ^ r_cam[31];
                        r_acc   <= '0;
                        r_cnt   <= gddrc_pkg::MUL_ITER;
                        r_state <= S_RDY;
                    end else if (r_state == S_RDY) begin
                        r_rdy   <= 32'(r_dir_y) + rd_nx;
                        r_rem   <= '0;
                        r_quo   <= 33'h1_0000_0000;
                        r_den   <= gddrc_pkg::abs32(r_rdx);
                        r_cnt   <= gddrc_pkg::DIV_ITER;
                        r_state <= S_DX;
                    end else if (r_state == S_SX) begin
                        r_sx    <= {8'd0, r_acc[47:16]};
                        r_ma    <= {32'd0, r_dy};
                        r_mb    <= {15'd0, fdist_y};
                        r_acc   <= '0;
                        r_cnt   <= gddrc_pkg::MUL_ITER;
                        r_state <= S_SY;
                    end else if (r_state == S_SY) begin
                        r_sy    <= {8'd0, r_acc[47:16]};
                        r_mx    <= CW'(r_cam_x[20:16]);
                        r_my    <= CW'(r_cam_y[20:16]);
                        r_steps <= '0;
                        r_side  <= 1'b0;
                        r_state <= S_STEP;
                    end else begin
                        r_o_col   <= r_col;
                        r_o_code  <= r_code;
                        r_o_side  <= r_side;
                        r_o_perp  <= r_perp;
                        r_o_lh    <= r_lh;
                        r_o_top   <= gddrc_pkg::sat16s(top_v);
                        r_o_bot   <= gddrc_pkg::sat16s(bot_v);
                        r_o_frac  <= fr;
                        r_o_fx    <= fpx[21] ? gddrc_pkg::FLOOR_MAX : fpx[20:0];
                        r_o_fy    <= fpy[21] ? gddrc_pkg::FLOOR_MAX : fpy[20:0];
                        r_o_esc   <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_STEP, S_CHK: begin
                    if ((r_state == S_STEP
                         && r_steps == gddrc_pkg::STEP_W'(gddrc_pkg::MAX_STEPS))
                        || (r_state == S_CHK && out_of_map)) begin
                        r_o_col  <= r_col;
                        r_o_code <= '0;
                        r_o_side <= 1'b0;
                        r_o_perp <= '0;
                        r_o_lh   <= '0;
                        r_o_top  <= '0;
                        r_o_bot  <= '0;
                        r_o_frac <= '0;
                        r_o_fx   <= '0;
                        r_o_fy   <= '0;
                        r_o_esc  <= 1'b1;
                        r_state  <= S_OUT;
                    end else if (r_state == S_CHK) begin
                        r_state <= S_RD;
                    end else begin
                        // ties step in y
                        if (r_sx < r_sy) begin
                            r_sx   <= r_sx + {8'd0, r_dx};
                            r_mx   <= r_rdx[31] ? r_mx - 1'b1 : r_mx + 1'b1;
                            r_side <= 1'b0;
                        end else begin
                            r_sy   <= r_sy + {8'd0, r_dy};
                            r_my   <= r_rdy[31] ? r_my - 1'b1 : r_my + 1'b1;
                            r_side <= 1'b1;
                        end
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_CHK;
                    end
                end
                S_RD: begin
                    if (r_rd != 4'd0) begin
                        r_code  <= r_rd;
                        r_state <= S_PERP;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_PERP: begin
                    r_perp  <= perp_c;
                    r_rem   <= '0;
                    r_quo   <= {5'd0, r_height, 16'd0};
                    r_den   <= {10'd0, perp_c};
                    r_cnt   <= gddrc_pkg::DIV_ITER;
                    r_state <= S_LH;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_column    = r_o_col;
    assign o_wall_code     = r_o_code;
    assign o_hit_side      = r_o_side;
    assign o_perp_distance = r_o_perp;
    assign o_line_height   = r_o_lh;
    assign o_draw_top      = $signed(r_o_top);
    assign o_draw_bottom   = $signed(r_o_bot);
    assign o_wall_fraction = r_o_frac;
    assign o_floor_point_x = r_o_fx;
    assign o_floor_point_y = r_o_fy;
    assign o_escaped       = r_o_esc;

    a_result_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while a result waits");

    a_cast_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_mode == gddrc_pkg::MODE_CAST) |=> !o_in_ready)
        else $error("still ready after a cast transfer");

    a_escape_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_escaped) |->
            (o_wall_code == 4'd0 && o_perp_distance == 22'd0 && o_line_height == 16'd0))
        else $error("escaped result carries hit data");

    a_hit_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |-> (o_wall_code != 4'd0))
        else $error("hit result with empty wall code");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_escaped) |-> (o_draw_top <= o_draw_bottom))
        else $error("draw span inverted");

endmodule

`default_nettype wire
